[rtl/core/sst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// types and codes shared by the sorted sparse term accumulator modules
// ----------------------------------------------------------------------------
package sst_pkg;

    // item kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_MERGED   = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;
    localparam logic [2:0] ST_READ_OK  = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        exponent;
        logic signed [31:0] coefficient;
        logic [3:0]         index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         term_count;
        logic [15:0]        out_exponent;
        logic signed [31:0] out_coefficient;
    } t_out_item;

    // table update operations
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_INSERT = 3'd1,
        OP_MERGE  = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_READ   = 3'd5
    } t_op;

    typedef struct packed {
        logic       capture;
        logic       commit;
        t_op        op;
        logic [2:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       coef_zero;
        logic       hit;
        logic       sum_zero;
        logic       full;
        logic       rd_ok;
    } t_dp_stat;

endpackage

[rtl/core/sst_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_ctrl
// sequencer: accepts an item, picks the table operation, loads the result
// ----------------------------------------------------------------------------
module sst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  sst_pkg::t_dp_stat i_stat,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output sst_pkg::t_dp_cmd  o_cmd
);
    import sst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_load;

    assign can_load = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = OP_NONE;
        o_cmd.status  = ST_EMPTY;
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        if (r_state == S_APPLY && can_load) begin
            o_cmd.commit = 1'b1;
            unique case (i_stat.kind)
                KIND_ADD: begin
                    if (i_stat.coef_zero) begin
                        o_cmd.status = ST_ZERO;
                    end else if (i_stat.hit) begin
                        if (i_stat.sum_zero) begin
                            o_cmd.op     = OP_REMOVE;
                            o_cmd.status = ST_REMOVED;
                        end else begin
                            o_cmd.op     = OP_MERGE;
                            o_cmd.status = ST_MERGED;
                        end
                    end else if (i_stat.full) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.op     = OP_INSERT;
                        o_cmd.status = ST_INSERTED;
                    end
                end
                KIND_READ: begin
                    if (i_stat.rd_ok) begin
                        o_cmd.op     = OP_READ;
                        o_cmd.status = ST_READ_OK;
                    end
                end
                KIND_CLEAR: begin
                    o_cmd.op = OP_CLEAR;
                end
                default: begin
                    o_cmd.status = ST_EMPTY;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_APPLY;
            end
            S_APPLY: begin
                if (can_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/core/sst_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_datapath
// term table with per-entry compare, one-step shift insert and remove
// ----------------------------------------------------------------------------
module sst_datapath #(
    parameter int MAX_TERMS = 16,
    parameter int EXP_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sst_pkg::t_in_item  i_in_data,
    input  sst_pkg::t_dp_cmd   i_cmd,
    output sst_pkg::t_dp_stat  o_stat,
    output sst_pkg::t_out_item o_out_data
);
    import sst_pkg::*;

    localparam int CW = $clog2(MAX_TERMS + 1);

    logic [EXP_BITS-1:0] r_exp  [MAX_TERMS];
    logic [EXP_BITS-1:0] n_exp  [MAX_TERMS];
    logic [31:0]         r_coef [MAX_TERMS];
    logic [31:0]         n_coef [MAX_TERMS];
    logic [CW-1:0]       r_count, n_count;
    t_in_item            r_item;
    logic [MAX_TERMS-1:0] r_gt, r_eq, r_rd_sel;
    logic [MAX_TERMS-1:0] n_gt, n_eq, n_rd_sel;
    t_out_item           r_out, n_out;

    logic [EXP_BITS+15:0] in_exp_wide, item_exp_wide;
    logic [EXP_BITS-1:0]  in_exp, item_exp;
    logic [EXP_BITS+15:0] rd_exp_wide;
    logic [EXP_BITS-1:0]  rd_exp;
    logic [31:0]          rd_coef, sel_coef, sum;
    logic [CW+4:0]        count_wide;

    // exponent reduced to the stored width
    assign in_exp_wide   = {{EXP_BITS{1'b0}}, i_in_data.exponent};
    assign in_exp        = in_exp_wide[EXP_BITS-1:0];
    assign item_exp_wide = {{EXP_BITS{1'b0}}, r_item.exponent};
    assign item_exp      = item_exp_wide[EXP_BITS-1:0];

    // compare against every held entry at capture time
    always_comb begin
        for (int k = 0; k < MAX_TERMS; k++) begin
            n_gt[k]     = (k < int'(r_count)) && (r_exp[k] > in_exp);
            n_eq[k]     = (k < int'(r_count)) && (r_exp[k] == in_exp);
            n_rd_sel[k] = (k < int'(r_count)) && (k == int'(i_in_data.index));
        end
    end

    // one-hot selects
    always_comb begin
        sel_coef = '0;
        rd_coef  = '0;
        rd_exp   = '0;
        for (int k = 0; k < MAX_TERMS; k++) begin
            if (r_eq[k]) sel_coef = sel_coef | r_coef[k];
            if (r_rd_sel[k]) begin
                rd_coef = rd_coef | r_coef[k];
                rd_exp  = rd_exp | r_exp[k];
            end
        end
    end

    assign sum         = sel_coef + 32'(r_item.coefficient);
    assign rd_exp_wide = {16'd0, rd_exp};

    always_comb begin
        o_stat.kind      = r_item.kind;
        o_stat.coef_zero = (r_item.coefficient == 32'sd0);
        o_stat.hit       = |r_eq;
        o_stat.sum_zero  = (sum == 32'd0);
        o_stat.full      = (r_count == CW'(MAX_TERMS));
        o_stat.rd_ok     = |r_rd_sel;
    end

    // table update
    always_comb begin
        n_exp   = r_exp;
        n_coef  = r_coef;
        n_count = r_count;
        if (i_cmd.commit) begin
            unique case (i_cmd.op)
                OP_INSERT: begin
                    for (int k = 0; k < MAX_TERMS; k++) begin
                        if (!r_gt[k]) begin
                            if (k == 0) begin
                                n_exp[k]  = item_exp;
                                n_coef[k] = 32'(r_item.coefficient);
                            end else if (r_gt[k-1]) begin
                                n_exp[k]  = item_exp;
                                n_coef[k] = 32'(r_item.coefficient);
                            end else begin
                                n_exp[k]  = r_exp[k-1];
                                n_coef[k] = r_coef[k-1];
                            end
                        end
                    end
                    n_count = r_count + CW'(1);
                end
                OP_MERGE: begin
                    for (int k = 0; k < MAX_TERMS; k++) begin
                        if (r_eq[k]) n_coef[k] = sum;
                    end
                end
                OP_REMOVE: begin
                    for (int k = 0; k < MAX_TERMS - 1; k++) begin
                        if (!r_gt[k]) begin
                            n_exp[k]  = r_exp[k+1];
                            n_coef[k] = r_coef[k+1];
                        end
                    end
                    n_count = r_count - CW'(1);
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    assign count_wide = {5'd0, n_count};

    always_comb begin
        n_out.status          = i_cmd.status;
        n_out.term_count      = count_wide[4:0];
        n_out.out_exponent    = '0;
        n_out.out_coefficient = '0;
        if (i_cmd.op == OP_READ) begin
            n_out.out_exponent    = rd_exp_wide[15:0];
            n_out.out_coefficient = signed'(rd_coef);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp  <= n_exp;
        r_coef <= n_coef;
        if (i_cmd.capture) begin
            r_item   <= i_in_data;
            r_gt     <= n_gt;
            r_eq     <= n_eq;
            r_rd_sel <= n_rd_sel;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

[rtl/core/sorted_sparse_term_accumulator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_sparse_term_accumulator_top
// polynomial term table sorted by falling exponent, with add, read and clear
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//
//  an item is accepted in the idle state, which registers the compare of the
//  item exponent against every held entry; the apply state then performs the
//  insert, merge, remove, read or clear and loads the output register
//  a stalled output holds the update cycle until the register is free
//  synchronous active-low reset empties the table; no clearing pass
//  entries beyond the held count are never read
// ----------------------------------------------------------------------------
module sorted_sparse_term_accumulator_top #(
    parameter int MAX_TERMS = 16,
    parameter int EXP_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sst_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sst_pkg::t_out_item o_out_data
);
    import sst_pkg::*;

    // command and status between sequencer and table
    t_dp_cmd  s_cmd;
    t_dp_stat s_stat;

    // sequencer: one item in flight, result held in the output register
    sst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (s_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (s_cmd)
    );

    // term table, compare vectors, coefficient adder and output register
    sst_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .EXP_BITS  (EXP_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (s_cmd),
        .o_stat     (s_stat),
        .o_out_data (o_out_data)
    );

    // an accepted transfer closes the input until the item is applied
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after an accepted transfer");

    // the output register is only loaded when it is free or draining
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.commit |-> (!o_out_valid || !i_out_stall))
        else $error("result overwrote a pending transfer");

    // no insert into a full table or onto an existing exponent
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.commit && s_cmd.op == OP_INSERT) |-> (!s_stat.full && !s_stat.hit))
        else $error("insert into a full table or onto an existing exponent");

    // merge only into a matching term with a nonzero sum
    a_merge_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.commit && s_cmd.op == OP_MERGE) |-> (s_stat.hit && !s_stat.sum_zero))
        else $error("merge without a matching term");

endmodule

[verif/sorted_sparse_term_accumulator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_sparse_term_accumulator_top_tb
// self-checking bench for the sorted polynomial term table
// ----------------------------------------------------------------------------
// a queue of add, read, clear and unused-kind items is built up front and fed
// to the block by a clocked driver with random gaps; a clocked monitor keeps
// its own copy of the term table, predicts one result per accepted item and
// compares every result transfer field by field; the result side stalls at
// random; a stretch in the middle of the run has no gaps and no stalls
// ----------------------------------------------------------------------------
module sorted_sparse_term_accumulator_top_tb;

    import sst_pkg::*;

    localparam int         MAX_TERMS      = 16;
    localparam int         EXP_BITS       = 16;
    localparam int         RANDOM_ITEMS   = 1000;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         IDLE_PERCENT   = 26;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    sorted_sparse_term_accumulator_top #(
        .MAX_TERMS(MAX_TERMS),
        .EXP_BITS (EXP_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // shadow of the term table, entry 0 holds the highest exponent
    logic [15:0] shadow_exp  [MAX_TERMS];
    logic [31:0] shadow_coef [MAX_TERMS];
    int          shadow_held = 0;

    t_in_item  pending_items[$];
    t_out_item term_results[$];
    int        error_count  = 0;
    int        idle_cycles  = 0;
    int        cycle_count  = 0;
    logic      in_taken     = 1'b0;
    logic      quiet;

    // no gaps and no stalls in this window
    assign quiet = (cycle_count >= 1000) && (cycle_count < 1600);

    // applies one item to the shadow table and returns the result it causes
    function automatic t_out_item apply_term_item(t_in_item it);
        t_out_item   r;
        int          pos;
        logic [31:0] sum;
        r = '0;
        r.status = ST_EMPTY;
        case (it.kind)
            KIND_ADD: begin
                if (it.coefficient == 0) begin
                    r.status = ST_ZERO;
                end else begin
                    pos = 0;
                    while (pos < shadow_held && shadow_exp[pos] > it.exponent) pos++;
                    if (pos < shadow_held && shadow_exp[pos] == it.exponent) begin
                        sum = shadow_coef[pos] + it.coefficient;
                        if (sum != 0) begin
                            shadow_coef[pos] = sum;
                            r.status = ST_MERGED;
                        end else begin
                            // sum cancelled: close the gap
                            for (int k = pos; k + 1 < shadow_held; k++) begin
                                shadow_exp[k]  = shadow_exp[k + 1];
                                shadow_coef[k] = shadow_coef[k + 1];
                            end
                            shadow_held--;
                            r.status = ST_REMOVED;
                        end
                    end else if (shadow_held >= MAX_TERMS) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int k = shadow_held; k > pos; k--) begin
                            shadow_exp[k]  = shadow_exp[k - 1];
                            shadow_coef[k] = shadow_coef[k - 1];
                        end
                        shadow_exp[pos]  = it.exponent;
                        shadow_coef[pos] = it.coefficient;
                        shadow_held++;
                        r.status = ST_INSERTED;
                    end
                end
            end
            KIND_READ: begin
                if (it.index < shadow_held) begin
                    r.status          = ST_READ_OK;
                    r.out_exponent    = shadow_exp[it.index];
                    r.out_coefficient = shadow_coef[it.index];
                end
            end
            KIND_CLEAR: begin
                shadow_held = 0;
            end
            default: ;
        endcase
        r.term_count = shadow_held[4:0];
        return r;
    endfunction

    task automatic push_item(logic [1:0] kind, logic [15:0] exponent,
                             logic [31:0] coefficient, logic [3:0] index);
        t_in_item it;
        it.kind        = kind;
        it.exponent    = exponent;
        it.coefficient = coefficient;
        it.index       = index;
        pending_items.push_back(it);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // driver: a new transfer is offered only once the last one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                if (pending_items.size() != 0 &&
                    (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
                    i_in_data  <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // monitor: predict on input transfers, check on output transfers
    always @(posedge i_clk) begin
        t_out_item want;
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (i_in_valid && !o_in_stall)
                term_results.push_back(apply_term_item(i_in_data));
            if (o_out_valid && !i_out_stall) begin
                if (term_results.size() == 0) begin
                    $error("result transfer with no result pending");
                    error_count++;
                end else begin
                    want = term_results.pop_front();
                    check_field("status", want.status, o_out_data.status);
                    check_field("term_count", want.term_count, o_out_data.term_count);
                    check_field("out_exponent", want.out_exponent, o_out_data.out_exponent);
                    check_field("out_coefficient", want.out_coefficient,
                                o_out_data.out_coefficient);
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [15:0] exp_pool [20];
        logic [15:0] ex;
        logic [31:0] co;
        int          pick;

        // directed: empty read, zero add, fill out of order, full, merge with
        // wrap while full, cancel to removal, read past end, unused kind, clear
        push_item(KIND_READ, 16'h0000, 32'h0, 4'd0);
        push_item(KIND_ADD, 16'h1234, 32'h0, 4'd0);
        for (int k = 0; k < MAX_TERMS; k++) begin
            pick = (k * 7) % MAX_TERMS;
            if (pick == 15)
                co = 32'h7fff_ffff;
            else if (pick == 0)
                co = 32'h8000_0000;
            else
                co = $urandom;
            push_item(KIND_ADD, 16'(pick * 4369), co, 4'(k));
        end
        push_item(KIND_READ, 16'hffff, 32'hffff_ffff, 4'd15);
        push_item(KIND_ADD, 16'h0001, 32'h5, 4'd0);
        push_item(KIND_ADD, 16'hffff, 32'h1, 4'd0);
        push_item(KIND_ADD, 16'h0000, 32'h8000_0000, 4'd0);
        push_item(KIND_READ, 16'h0000, 32'h0, 4'd15);
        push_item(KIND_UNUSED, 16'hffff, 32'hffff_ffff, 4'd15);
        push_item(KIND_CLEAR, 16'h5a5a, 32'h1234_5678, 4'd9);

        // random: adds drawn mostly from a small exponent set so terms merge,
        // cancel and the table fills up; small coefficients cancel often
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                for (int k = 0; k < 20; k++)
                    exp_pool[k] = ($urandom_range(3) == 0) ? 16'($urandom_range(31))
                                                           : 16'($urandom);
            end
            ex   = $urandom;
            co   = $urandom;
            pick = $urandom_range(99);
            if (pick < 2) begin
                push_item(KIND_CLEAR, ex, co, 4'($urandom));
            end else if (pick < 3) begin
                push_item(KIND_UNUSED, ex, co, 4'($urandom));
            end else if (pick < 28) begin
                push_item(KIND_READ, ex, co, 4'($urandom));
            end else begin
                if ($urandom_range(9) != 0)
                    ex = exp_pool[$urandom_range(19)];
                pick = $urandom_range(99);
                if (pick < 60) begin
                    co = $urandom_range(3, 1);
                    if ($urandom_range(1)) co = -co;
                end else if (pick < 65) begin
                    co = 32'h0;
                end else if (pick < 75) begin
                    co = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
                end
                push_item(KIND_ADD, ex, co, 4'($urandom));
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (term_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/sst_pkg.sv
rtl/core/sst_ctrl.sv
rtl/core/sst_datapath.sv
rtl/core/sorted_sparse_term_accumulator_top.sv
verif/sorted_sparse_term_accumulator_top_tb.sv
